// File: rtl/ppool_pkg.sv
// ----------------------------------------------------------------------------
// ppool_pkg
// Shared types, constants and channel arithmetic for the 2x2 pooling
// downscaler: pixel layout, register map, combine rules, dimension clamps.
// ----------------------------------------------------------------------------
`default_nettype none

package ppool_pkg;

  // Image limits and derived widths
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = $clog2(PAIR_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WCNT_W     = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W     = $clog2(MAX_HEIGHT + 1);

  // Register map
  localparam int DIM_W    = 12;
  localparam int MODE_W   = 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int REGIDX_W = 2;

  localparam logic [REGIDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [REGIDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [REGIDX_W-1:0] REG_MODE   = 2'd2;

  localparam logic [DIM_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 12'd480;

  // Combine rules; the unused code behaves as maximum
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AVG = 2'd2;

  // One RGB888 pixel, red in the low byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  localparam int PIX_W  = $bits(pixel_t);
  localparam int PAIR_W = 2 * PIX_W;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [MODE_W-1:0] mode;
    logic              restart;
  } cfg_t;

  // Bottom-row payload waiting for the line buffer read
  typedef struct packed {
    pixel_t bl;
    pixel_t br;
    logic   frame_end;
  } stage_t;

  function automatic logic [WCNT_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
    int vi;
    vi = int'(v);
    if (vi < 2) return WCNT_W'(2);
    if (vi > MAX_WIDTH) return WCNT_W'(MAX_WIDTH);
    return WCNT_W'(vi);
  endfunction

  function automatic logic [HCNT_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
    int vi;
    vi = int'(v);
    if (vi < 2) return HCNT_W'(2);
    if (vi > MAX_HEIGHT) return HCNT_W'(MAX_HEIGHT);
    return HCNT_W'(vi);
  endfunction

  function automatic logic [7:0] avg2(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  function automatic logic [7:0] chan_combine(input logic [7:0] tl, input logic [7:0] tr,
                                              input logic [7:0] bl, input logic [7:0] br,
                                              input logic [MODE_W-1:0] mode);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r;
    unique case (mode)
      MODE_MIN: begin
        a = (tl < tr) ? tl : tr;
        b = (bl < br) ? bl : br;
        r = (a < b) ? a : b;
      end
      MODE_AVG: begin
        a = avg2(bl, br);
        b = avg2(tr, a);
        r = avg2(tl, b);
      end
      default: begin
        a = (tl > tr) ? tl : tr;
        b = (bl > br) ? bl : br;
        r = (a > b) ? a : b;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ppool_cfg.sv
// ----------------------------------------------------------------------------
// ppool_cfg
// APB-style register file: image width, image height, combine mode.
// Writing a dimension raises a one-cycle restart toward the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module ppool_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ppool_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ppool_pkg::DATA_W-1:0]  pwdata,
  output logic      [ppool_pkg::DATA_W-1:0]  prdata,
  output logic                               pready,
  output ppool_pkg::cfg_t                    cfg
);

  logic [ppool_pkg::DIM_W-1:0]    width_r;
  logic [ppool_pkg::DIM_W-1:0]    height_r;
  logic [ppool_pkg::MODE_W-1:0]   mode_r;
  logic [ppool_pkg::REGIDX_W-1:0] idx;
  logic                           wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ppool_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  // Capture register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ppool_pkg::WIDTH_RST;
      height_r <= ppool_pkg::HEIGHT_RST;
      mode_r   <= ppool_pkg::MODE_MAX;
    end else if (wr_en) begin
      unique case (idx)
        ppool_pkg::REG_WIDTH:  width_r  <= pwdata[ppool_pkg::DIM_W-1:0];
        ppool_pkg::REG_HEIGHT: height_r <= pwdata[ppool_pkg::DIM_W-1:0];
        ppool_pkg::REG_MODE:   mode_r   <= pwdata[ppool_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      ppool_pkg::REG_WIDTH:  prdata = ppool_pkg::DATA_W'(width_r);
      ppool_pkg::REG_HEIGHT: prdata = ppool_pkg::DATA_W'(height_r);
      ppool_pkg::REG_MODE:   prdata = ppool_pkg::DATA_W'(mode_r);
      default:               prdata = '0;
    endcase
  end

  assign cfg.width   = width_r;
  assign cfg.height  = height_r;
  assign cfg.mode    = mode_r;
  assign cfg.restart = wr_en & ((idx == ppool_pkg::REG_WIDTH) | (idx == ppool_pkg::REG_HEIGHT));

endmodule

`default_nettype wire

// File: rtl/ppool_line_buf.sv
// ----------------------------------------------------------------------------
// ppool_line_buf
// Line buffer holding the top pixel pair {TL, TR} of every 2x2 block.
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module ppool_line_buf (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [ppool_pkg::SLOT_W-1:0]  wr_slot,
  input  wire logic [ppool_pkg::PAIR_W-1:0]  wr_pair,
  input  wire logic                          rd_en,
  input  wire logic [ppool_pkg::SLOT_W-1:0]  rd_slot,
  output logic      [ppool_pkg::PAIR_W-1:0]  rd_pair
);

  logic [ppool_pkg::PAIR_W-1:0] mem [ppool_pkg::PAIR_DEPTH];
  logic [ppool_pkg::PAIR_W-1:0] rd_pair_r;

  // Store the top pair
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_pair;
    end
  end

  // Fetch for the bottom row; hold while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pair_r <= mem[rd_slot];
    end
  end

  assign rd_pair = rd_pair_r;

endmodule

`default_nettype wire

// File: rtl/ppool_combine.sv
// ----------------------------------------------------------------------------
// ppool_combine
// Joins the fetched top pair with the bottom pair, applies the combine rule
// per channel and holds the pooled pixel in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppool_combine (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          stg_valid,
  input  wire ppool_pkg::stage_t             stg,
  input  wire logic [ppool_pkg::PAIR_W-1:0]  top_pair,
  input  wire logic [ppool_pkg::MODE_W-1:0]  mode,
  output logic                               stg_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output ppool_pkg::pixel_t                  out_pix,
  output logic                               out_last
);

  ppool_pkg::pixel_t tl;
  ppool_pkg::pixel_t tr;
  ppool_pkg::pixel_t res;
  logic              valid_r;
  ppool_pkg::pixel_t pix_r;
  logic              last_r;

  assign tl = ppool_pkg::pixel_t'(top_pair[ppool_pkg::PAIR_W-1:ppool_pkg::PIX_W]);
  assign tr = ppool_pkg::pixel_t'(top_pair[ppool_pkg::PIX_W-1:0]);

  // Combine channel by channel
  always_comb begin
    res.red   = ppool_pkg::chan_combine(tl.red,   tr.red,   stg.bl.red,   stg.br.red,   mode);
    res.green = ppool_pkg::chan_combine(tl.green, tr.green, stg.bl.green, stg.br.green, mode);
    res.blue  = ppool_pkg::chan_combine(tl.blue,  tr.blue,  stg.bl.blue,  stg.br.blue,  mode);
  end

  assign stg_ready = ~valid_r | out_ready;

  // Output register: load when empty or drained this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (stg_ready) begin
      valid_r <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready && stg_valid) begin
      pix_r  <= res;
      last_r <= stg.frame_end;
    end
  end

  assign out_valid = valid_r;
  assign out_pix   = pix_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

// File: rtl/pixel_pool_2x2_downscale.sv
// ----------------------------------------------------------------------------
// pixel_pool_2x2_downscale
// 2x2 pooling downscaler for an RGB888 raster stream: max, min or nested
// floor average of each aligned block, top pair kept in a line buffer.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  in_      | slave     | one input pixel, raster order
//  out_     | master    | one pooled pixel per 2x2 block, tlast on frame end
//  cfg_     | APB       | width (0x0), height (0x4), combine mode (0x8)
//
//  One pixel per cycle while the output is not stalled; a pooled pixel leaves
//  via the line buffer read, then the output register.
//  Reset clears the position counters, held pixel and pipeline; the line
//  buffer needs no clearing, every bottom-row read hits an entry written
//  earlier in the same row pair. in_tready drops only while the fetch stage
//  and the output register are both full and out_tready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_pool_2x2_downscale (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,   // in_red, in_green, in_blue
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [23:0]                   out_tdata,  // out_red, out_green, out_blue
  output logic                               out_tlast,  // frame_end
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [ppool_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [ppool_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic      [ppool_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                               cfg_pready
);

  ppool_pkg::cfg_t                 cfg;
  ppool_pkg::pixel_t               pix;
  logic                            accept;
  logic [ppool_pkg::COL_W-1:0]     col_r;
  logic [ppool_pkg::COL_W-1:0]     col_nxt;
  logic [ppool_pkg::ROW_W-1:0]     row_r;
  logic [ppool_pkg::ROW_W-1:0]     row_nxt;
  ppool_pkg::pixel_t               held_r;
  logic [ppool_pkg::WCNT_W-1:0]    w;
  logic [ppool_pkg::HCNT_W-1:0]    h;
  logic [ppool_pkg::WCNT_W-1:0]    col_inc;
  logic [ppool_pkg::HCNT_W-1:0]    row_inc;
  logic [ppool_pkg::WCNT_W-1:0]    last_col;
  logic [ppool_pkg::HCNT_W-1:0]    last_row;
  logic [ppool_pkg::SLOT_W-1:0]    slot;
  logic                            top_wr;
  logic                            bot_rd;
  logic                            stg_valid_r;
  logic                            stg_valid_nxt;
  ppool_pkg::stage_t               stg_r;
  logic                            stg_ready;
  logic [ppool_pkg::PAIR_W-1:0]    top_pair;
  ppool_pkg::pixel_t               out_pix;

  ppool_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign pix       = ppool_pkg::pixel_t'(in_tdata);
  assign in_tready = ~stg_valid_r | stg_ready;
  assign accept    = in_tvalid & in_tready;

  // Position arithmetic on clamped dimensions
  assign w        = ppool_pkg::clamp_width(cfg.width);
  assign h        = ppool_pkg::clamp_height(cfg.height);
  assign col_inc  = ppool_pkg::WCNT_W'(col_r) + 1'b1;
  assign row_inc  = ppool_pkg::HCNT_W'(row_r) + 1'b1;
  assign last_col = {w[ppool_pkg::WCNT_W-1:1], 1'b0} - 1'b1;
  assign last_row = {h[ppool_pkg::HCNT_W-1:1], 1'b0} - 1'b1;
  assign slot     = ppool_pkg::SLOT_W'(col_r >> 1);

  assign top_wr = accept & col_r[0] & ~row_r[0];
  assign bot_rd = accept & col_r[0] & row_r[0];

  // Advance the raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg.restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_inc >= w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h) ? '0 : ppool_pkg::ROW_W'(row_inc);
      end else begin
        col_nxt = ppool_pkg::COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (accept && !col_r[0]) begin
        held_r <= pix;
      end
    end
  end

  ppool_line_buf u_line_buf (
    .clk     (clk),
    .wr_en   (top_wr),
    .wr_slot (slot),
    .wr_pair ({held_r, pix}),
    .rd_en   (bot_rd),
    .rd_slot (slot),
    .rd_pair (top_pair)
  );

  // Fetch stage: bottom pair is registered alongside the line buffer read
  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_tready) begin
      stg_valid_nxt = bot_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (bot_rd) begin
      stg_r.bl        <= held_r;
      stg_r.br        <= pix;
      stg_r.frame_end <= (ppool_pkg::WCNT_W'(col_r) == last_col) &&
                         (ppool_pkg::HCNT_W'(row_r) == last_row);
    end
  end

  ppool_combine u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .stg_valid (stg_valid_r),
    .stg       (stg_r),
    .top_pair  (top_pair),
    .mode      (cfg.mode),
    .stg_ready (stg_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pix   (out_pix),
    .out_last  (out_tlast)
  );

  assign out_tdata = out_pix;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2x2 pooling downscaler. A scoreboard class
// keeps its own copy of the line buffer, counters and registers, predicts
// every pooled pixel from the accepted input pixels and checks each output
// transaction field by field. Stimulus: directed blocks for every combine
// rule, odd and clamped sizes, then random frames under varying backpressure.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [23:0] pix;   // out_red, out_green, out_blue from the lowest bit up
  logic        last;
} pooled_t;

module testbench;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 600;
  localparam logic [ppool_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  // Predict pooled pixels from accepted input pixels and check the outputs
  class pool_scoreboard;
    logic [47:0] top_pairs [ppool_pkg::PAIR_DEPTH];
    logic [23:0] held_left;
    int unsigned col;
    int unsigned row;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [1:0]  mode_reg;
    pooled_t     expected_q [$];
    int          errors;
    int          pixels_seen;
    int          pooled_checked;

    function new();
      held_left      = '0;
      col            = 0;
      row            = 0;
      width_reg      = 12'd640;
      height_reg     = 12'd480;
      mode_reg       = ppool_pkg::MODE_MAX;
      errors         = 0;
      pixels_seen    = 0;
      pooled_checked = 0;
    endfunction

    function int unsigned used_dim(logic [11:0] v, int unsigned hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return 32'(v);
    endfunction

    function logic [7:0] pool_channel(logic [7:0] tl, logic [7:0] tr,
                                      logic [7:0] bl, logic [7:0] br,
                                      logic [1:0] mode);
      logic [8:0] a;
      logic [7:0] b;
      logic [7:0] c;
      case (mode)
        ppool_pkg::MODE_MIN: begin
          b = (tl < tr) ? tl : tr;
          c = (bl < br) ? bl : br;
          return (b < c) ? b : c;
        end
        ppool_pkg::MODE_AVG: begin
          a = ({1'b0, bl} + {1'b0, br}) >> 1;
          a = ({1'b0, tr} + a) >> 1;
          a = ({1'b0, tl} + a) >> 1;
          return a[7:0];
        end
        default: begin
          b = (tl > tr) ? tl : tr;
          c = (bl > br) ? bl : br;
          return (b > c) ? b : c;
        end
      endcase
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        ppool_pkg::REG_WIDTH: begin
          width_reg = value[11:0];
          col = 0;
          row = 0;
        end
        ppool_pkg::REG_HEIGHT: begin
          height_reg = value[11:0];
          col = 0;
          row = 0;
        end
        ppool_pkg::REG_MODE: mode_reg = value[1:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [23:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned slot;
      logic [23:0] tl;
      logic [23:0] tr;
      pooled_t     e;
      w = used_dim(width_reg, ppool_pkg::MAX_WIDTH);
      h = used_dim(height_reg, ppool_pkg::MAX_HEIGHT);
      slot = (col >> 1) % ppool_pkg::PAIR_DEPTH;
      pixels_seen++;
      if (col[0] == 1'b0) begin
        held_left = pix;
      end else if (row[0] == 1'b0) begin
        top_pairs[slot] = {held_left, pix};
      end else begin
        tl = top_pairs[slot][47:24];
        tr = top_pairs[slot][23:0];
        for (int k = 0; k < 3; k++) begin
          e.pix[8*k +: 8] = pool_channel(tl[8*k +: 8], tr[8*k +: 8],
                                         held_left[8*k +: 8], pix[8*k +: 8], mode_reg);
        end
        e.last = (col == (w & ~32'd1) - 1) && (row == (h & ~32'd1) - 1);
        expected_q.push_back(e);
      end
      // Advance the raster position
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void check_pooled(logic [23:0] pix, logic last);
      pooled_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected pooled pixel %06h last %0d", pix, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      pooled_checked++;
      if (pix[7:0] !== e.pix[7:0]) begin
        $error("out_red: expected %0d, actual %0d", e.pix[7:0], pix[7:0]);
        errors++;
      end
      if (pix[15:8] !== e.pix[15:8]) begin
        $error("out_green: expected %0d, actual %0d", e.pix[15:8], pix[15:8]);
        errors++;
      end
      if (pix[23:16] !== e.pix[23:16]) begin
        $error("out_blue: expected %0d, actual %0d", e.pix[23:16], pix[23:16]);
        errors++;
      end
      if (last !== e.last) begin
        $error("frame_end: expected %0d, actual %0d", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [23:0] in_tdata = '0;    // in_red, in_green, in_blue
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [ppool_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [ppool_pkg::DATA_W-1:0] cfg_pwdata = '0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [23:0] out_tdata;        // out_red, out_green, out_blue
  wire         out_tlast;        // frame_end
  wire  [ppool_pkg::DATA_W-1:0] cfg_prdata;
  wire         cfg_pready;

  pool_scoreboard sb = new();
  int  send_idle_pct = 19;
  int  recv_idle_pct = 48;
  logic hold_start = 1'b0;
  int  hold_left = 0;
  int  cycle_count = 0;
  int  settings_run = 0;

  pixel_pool_2x2_downscale dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("pixel_pool_2x2_downscale: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, long hold on request, check each output transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_pooled(out_tdata, out_tlast);
    end
    if (hold_start) begin
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [23:0] random_pixel();
    logic [23:0] p;
    p = 24'($urandom);
    // Bias some channels toward the extremes so ties and limits show up
    if ($urandom_range(3) == 0) begin
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(2))
          0: p[8*k +: 8] = 8'h00;
          1: p[8*k +: 8] = 8'hFF;
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  task automatic send_pixel(input logic [23:0] pix);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(pix);
  endtask

  // Hold the input until every expected pooled pixel has left the block
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write, then read back the same register
  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] mask;
    mask = (idx == ppool_pkg::REG_MODE) ? 32'h3 : 32'hFFF;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, value);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if ((readback & mask) !== (value & mask)) begin
      $error("register %0d readback: expected %0d, actual %0d", idx, value & mask,
             readback & mask);
      sb.errors++;
    end
  endtask

  task automatic set_frame(input int w, input int h, input logic [1:0] mode);
    write_register(ppool_pkg::REG_WIDTH, w);
    write_register(ppool_pkg::REG_HEIGHT, h);
    write_register(ppool_pkg::REG_MODE, 32'(mode));
    settings_run++;
  endtask

  // One random setting: full frames, sometimes cut short, sometimes a mode change
  task automatic random_frame(inout int sent);
    int w_raw;
    int h_raw;
    int w;
    int h;
    int total;
    int mode_at;
    w_raw = ($urandom_range(15) == 0) ? $urandom_range(1) : $urandom_range(2, 24);
    h_raw = ($urandom_range(15) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
    set_frame(w_raw, h_raw, 2'($urandom_range(3)));
    w = sb.used_dim(12'(w_raw), ppool_pkg::MAX_WIDTH);
    h = sb.used_dim(12'(h_raw), ppool_pkg::MAX_HEIGHT);
    total = w * h * $urandom_range(1, 2);
    if ($urandom_range(7) == 0) total = $urandom_range(1, w * h - 1);
    mode_at = ($urandom_range(5) == 0) ? $urandom_range(1, total) : -1;
    for (int n = 0; n < total; n++) begin
      if (n == mode_at) begin
        wait_drained();
        write_register(ppool_pkg::REG_MODE, $urandom_range(3));
      end
      send_pixel(random_pixel());
    end
    sent += total;
    wait_drained();
  endtask

  logic [23:0] block_pixels [4] = '{24'h80_00_FF, 24'h7F_FF_00, 24'h00_FE_01, 24'hFF_01_FE};

  initial begin
    int sent;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one block per combine rule, spare mode with clamped size
    set_frame(2, 2, ppool_pkg::MODE_MAX);
    for (int k = 0; k < 4; k++) send_pixel(block_pixels[k]);
    wait_drained();
    write_register(ppool_pkg::REG_MODE, 32'(ppool_pkg::MODE_MIN));
    for (int k = 0; k < 4; k++) send_pixel(block_pixels[k]);
    wait_drained();
    write_register(ppool_pkg::REG_MODE, 32'(ppool_pkg::MODE_AVG));
    for (int k = 0; k < 4; k++) send_pixel(block_pixels[k]);
    wait_drained();
    set_frame(0, 1, MODE_SPARE);
    for (int k = 0; k < 4; k++) send_pixel(block_pixels[3 - k]);
    wait_drained();
    // Odd width and height: trailing column and row drop out
    set_frame(3, 3, ppool_pkg::MODE_AVG);
    for (int k = 0; k < 9; k++) send_pixel((k % 2) ? 24'hFFFFFF : 24'h000000);
    wait_drained();

    // Random phase: sender idles lightly, receiver heavily
    sent = 0;
    while (sent < PHASE_ITEMS) random_frame(sent);

    // Random phase: the other way round
    send_idle_pct = 48;
    recv_idle_pct = 19;
    sent = 0;
    while (sent < PHASE_ITEMS) random_frame(sent);

    // Long receiver hold while the sender keeps offering pixels
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_frame(16, 6, 2'($urandom_range(3)));
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    for (int n = 0; n < 96; n++) send_pixel(random_pixel());
    wait_drained();

    // Random phase: no idling
    sent = 0;
    while (sent < PHASE_ITEMS) random_frame(sent);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input pixels and %0d pooled pixels over %0d settings,",
             sb.pixels_seen, sb.pooled_checked, settings_run);
    $display("all combine rules, odd and clamped sizes, restarts and a long output stall");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("pixel_pool_2x2_downscale: match");
    end else begin
      $display("pixel_pool_2x2_downscale: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ppool_pkg.sv
rtl/ppool_cfg.sv
rtl/ppool_line_buf.sv
rtl/ppool_combine.sv
rtl/pixel_pool_2x2_downscale.sv
tb/testbench.sv
